// ----- sv/ipslb_pkg.sv -----
// Package for the interleaved PE slot load balancer.
// Holds field widths, default parameters and the saturating load add.
// Used by the interfaces, the top level and the checker.
package ipslb_pkg;

	localparam int ROW_W = 19;
	localparam int NZ_W = 14;
	localparam int LOAD_W = 25;
	localparam int RUN_W = 27;

	localparam int DEF_NUM_PES = 128;
	localparam int DEF_SLOTS = 5;
	localparam int DEF_PAD = 1;

	typedef logic [LOAD_W-1:0] load_t;
	typedef logic [RUN_W-1:0] run_t;

	localparam load_t LOAD_MAX = '1;
	localparam run_t RUN_MAX = '1;

	function automatic load_t sat_add(load_t a, logic [NZ_W-1:0] b);
		logic [LOAD_W:0] s;
		s = {1'b0, a} + (LOAD_W + 1)'(b);
		return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
	endfunction

endpackage

// ----- sv/ipslb_if.sv -----
// Valid/ready channels of the load balancer: row requests in, results out.
// Depends on ipslb_pkg for the field widths.
interface ipslb_row_if;
	logic valid;
	logic ready;
	logic [ipslb_pkg::ROW_W-1:0] local_row;
	logic [ipslb_pkg::NZ_W-1:0] row_nonzeros;
	logic tile_last;

	modport source(output valid, local_row, row_nonzeros, tile_last, input ready);
	modport sink(input valid, local_row, row_nonzeros, tile_last, output ready);
endinterface

interface ipslb_res_if;
	logic valid;
	logic ready;
	logic [ipslb_pkg::LOAD_W-1:0] baseline_max_load;
	logic [ipslb_pkg::LOAD_W-1:0] slot_max_load;
	logic [ipslb_pkg::RUN_W-1:0] slot_run_length;
	logic tile_done;

	modport source(output valid, baseline_max_load, slot_max_load, slot_run_length,
		tile_done, input ready);
	modport sink(input valid, baseline_max_load, slot_max_load, slot_run_length,
		tile_done, output ready);
endinterface

// ----- sv/interleaved_pe_slot_load_balancer.sv -----
// Greedy least-loaded interleave slot assignment, one tile row per request.
// Depends on ipslb_pkg and the channel interfaces in ipslb_if.sv.
//
// One row request is accepted every cycle unless a held result backs up the stages. The
// first stage splits the row number into its PE, the second reads the PE's load row
// from a single-port-read memory, and the result register takes the totals while the
// updated row is written back. A held result stalls all stages, so at most three
// requests are in flight. The write-back of a row is forwarded to a request for the
// same PE that reads in the same cycle. A valid bit per PE row stands in for the
// cleared memory, so the stores are empty right after reset and right after a row
// marked last, with no clearing pass.
module interleaved_pe_slot_load_balancer #(
	parameter int NUM_PES = ipslb_pkg::DEF_NUM_PES,
	parameter int SLOTS = ipslb_pkg::DEF_SLOTS,
	parameter int PAD = ipslb_pkg::DEF_PAD
) (
	input logic clk,
	input logic arst_n,
	ipslb_row_if.sink rows,
	ipslb_res_if.source results
);

	localparam int ROW_W = ipslb_pkg::ROW_W;
	localparam int LOAD_W = ipslb_pkg::LOAD_W;
	localparam int RUN_W = ipslb_pkg::RUN_W;
	localparam int PE_W = $clog2(NUM_PES);
	localparam int PICK_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SHIFT = ROW_W + PE_W;
	localparam int PROD_W = SHIFT + ROW_W;
	localparam longint unsigned RECIP_FULL = (64'd1 << SHIFT) / 64'(NUM_PES);
	localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_FULL);
	localparam int MUL_W = LOAD_W + 1 + $clog2(SLOTS + 1) + 1;

	typedef logic [SLOTS:0][LOAD_W-1:0] pe_row_t;

	pe_row_t row_mem [NUM_PES];
	logic [NUM_PES-1:0] vld_q;

	logic s1_valid_q;
	logic [ROW_W-1:0] row_s1;
	logic [ROW_W-1:0] quo_s1;
	logic [ipslb_pkg::NZ_W-1:0] nz_s1;
	logic last_s1;

	logic s2_valid_q;
	logic [PE_W-1:0] pe_s2;
	logic [ipslb_pkg::NZ_W-1:0] nz_s2;
	logic last_s2;
	logic fwd_s2;
	logic hit_s2;
	pe_row_t rd_row_s2;
	pe_row_t fwd_row_q;

	ipslb_pkg::load_t base_peak_q;
	ipslb_pkg::load_t slot_peak_q;

	logic out_valid_q;
	ipslb_pkg::load_t out_base_q;
	ipslb_pkg::load_t out_slot_q;
	ipslb_pkg::run_t out_run_q;
	logic out_done_q;

	logic s2_fire;
	logic s1_adv;
	logic in_fire;
	logic [PROD_W-1:0] prod;
	logic [PE_W:0] rem_raw;
	logic [PE_W-1:0] pe_calc;

	pe_row_t cur_row;
	pe_row_t new_row;
	ipslb_pkg::load_t pe_sum;
	ipslb_pkg::load_t slot_sum;
	ipslb_pkg::load_t best;
	logic [PICK_W-1:0] pick;
	ipslb_pkg::load_t base_pk;
	ipslb_pkg::load_t slot_pk;
	logic [MUL_W-1:0] run_full;
	ipslb_pkg::run_t run_sat;

	assign s2_fire = s2_valid_q && (!out_valid_q || results.ready);
	assign s1_adv = s1_valid_q && (!s2_valid_q || s2_fire);
	assign rows.ready = !s1_valid_q || s1_adv;
	assign in_fire = rows.valid && rows.ready;

	assign prod = PROD_W'(rows.local_row) * RECIP;

	always_comb begin
		rem_raw = (PE_W + 1)'(row_s1 - ROW_W'(quo_s1 * ROW_W'(NUM_PES)));
		if (rem_raw >= (PE_W + 1)'(NUM_PES)) begin
			pe_calc = PE_W'(rem_raw - (PE_W + 1)'(NUM_PES));
		end else begin
			pe_calc = PE_W'(rem_raw);
		end
	end

	always_comb begin
		if (fwd_s2) begin
			cur_row = fwd_row_q;
		end else if (hit_s2) begin
			cur_row = rd_row_s2;
		end else begin
			cur_row = '0;
		end
		pick = '0;
		best = cur_row[1];
		for (int s = 1; s < SLOTS; s++) begin
			if (cur_row[s + 1] < best) begin
				best = cur_row[s + 1];
				pick = PICK_W'(s);
			end
		end
		pe_sum = ipslb_pkg::sat_add(cur_row[0], nz_s2);
		slot_sum = ipslb_pkg::sat_add(best, nz_s2);
		new_row = cur_row;
		new_row[0] = pe_sum;
		new_row[pick + 1] = slot_sum;
		base_pk = (pe_sum > base_peak_q) ? pe_sum : base_peak_q;
		slot_pk = (slot_sum > slot_peak_q) ? slot_sum : slot_peak_q;
		run_full = (MUL_W'(slot_pk) + MUL_W'(PAD)) * MUL_W'(SLOTS);
		if (run_full > MUL_W'(ipslb_pkg::RUN_MAX)) begin
			run_sat = ipslb_pkg::RUN_MAX;
		end else begin
			run_sat = RUN_W'(run_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			vld_q <= '0;
			fwd_s2 <= 1'b0;
			hit_s2 <= 1'b0;
			base_peak_q <= '0;
			slot_peak_q <= '0;
		end else begin
			if (rows.ready) begin
				s1_valid_q <= in_fire;
			end
			if (s1_adv) begin
				fwd_s2 <= s2_fire && !last_s2 && (pe_s2 == pe_calc);
				hit_s2 <= !(s2_fire && last_s2) && vld_q[pe_calc];
			end
			if (!s2_valid_q || s2_fire) begin
				s2_valid_q <= s1_adv;
			end
			if (s2_fire) begin
				if (last_s2) begin
					vld_q <= '0;
					base_peak_q <= '0;
					slot_peak_q <= '0;
				end else begin
					vld_q[pe_s2] <= 1'b1;
					base_peak_q <= base_pk;
					slot_peak_q <= slot_pk;
				end
			end
			if (!out_valid_q || results.ready) begin
				out_valid_q <= s2_fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_s1 <= rows.local_row;
			quo_s1 <= prod[SHIFT +: ROW_W];
			nz_s1 <= rows.row_nonzeros;
			last_s1 <= rows.tile_last;
		end
		if (s1_adv) begin
			pe_s2 <= pe_calc;
			nz_s2 <= nz_s1;
			last_s2 <= last_s1;
		end
		if (s2_fire) begin
			fwd_row_q <= new_row;
			out_base_q <= base_pk;
			out_slot_q <= slot_pk;
			out_run_q <= run_sat;
			out_done_q <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rd_row_s2 <= row_mem[pe_calc];
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			row_mem[pe_s2] <= new_row;
		end
	end

	assign results.valid = out_valid_q;
	assign results.baseline_max_load = out_base_q;
	assign results.slot_max_load = out_slot_q;
	assign results.slot_run_length = out_run_q;
	assign results.tile_done = out_done_q;

endmodule

// ----- sv/ipslb_checker.sv -----
// Port-level checks for the interleaved PE slot load balancer.
// Depends on ipslb_pkg; bound to the top level at the end of this file.
module ipslb_checker #(
	parameter int SLOTS = ipslb_pkg::DEF_SLOTS,
	parameter int PAD = ipslb_pkg::DEF_PAD
) (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic [ipslb_pkg::LOAD_W-1:0] res_base,
	input logic [ipslb_pkg::LOAD_W-1:0] res_slot,
	input logic [ipslb_pkg::RUN_W-1:0] res_run,
	input logic res_done
);

	localparam int CHK_W = ipslb_pkg::LOAD_W + 1 + $clog2(SLOTS + 1) + 1;

	logic [CHK_W-1:0] run_exp;
	logic [CHK_W-1:0] slot_span;
	logic res_fire;
	logic prev_done_q;
	logic [ipslb_pkg::LOAD_W-1:0] prev_base_q;

	assign res_fire = res_valid && res_ready;
	assign run_exp = (CHK_W'(res_slot) + CHK_W'(PAD)) * CHK_W'(SLOTS);
	assign slot_span = CHK_W'(res_slot) * CHK_W'(SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_done_q <= 1'b1;
			prev_base_q <= '0;
		end else if (res_fire) begin
			prev_done_q <= res_done;
			prev_base_q <= res_base;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (run_exp > CHK_W'(ipslb_pkg::RUN_MAX)
			? (res_run == ipslb_pkg::RUN_MAX) : (CHK_W'(res_run) == run_exp)))
		else $error("run length does not follow slot maximum");

	a_slot_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_slot <= res_base) && (CHK_W'(res_base) <= slot_span))
		else $error("slot maximum outside the bounds set by the baseline");

	a_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire && !prev_done_q |-> res_base >= prev_base_q)
		else $error("baseline maximum fell within a tile");

endmodule

bind interleaved_pe_slot_load_balancer ipslb_checker #(
	.SLOTS(SLOTS),
	.PAD(PAD)
) u_ipslb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(results.valid),
	.res_ready(results.ready),
	.res_base(results.baseline_max_load),
	.res_slot(results.slot_max_load),
	.res_run(results.slot_run_length),
	.res_done(results.tile_done)
);

// ----- bench/tb_top.sv -----
// Testbench for interleaved_pe_slot_load_balancer: drives row requests, predicts the
// per-tile baseline and slot peaks in a local model and checks every result in order.
// Depends on ipslb_pkg and the channel interfaces in ipslb_if.sv.
module tb_top;

	localparam int NUM_PES = ipslb_pkg::DEF_NUM_PES;
	localparam int SLOTS = ipslb_pkg::DEF_SLOTS;
	localparam int PAD = ipslb_pkg::DEF_PAD;
	localparam int ROW_W = ipslb_pkg::ROW_W;
	localparam int NZ_W = ipslb_pkg::NZ_W;
	localparam int ROWS_PER_TILE = 393216;
	localparam int WINDOW = 8192;
	localparam int RANDOM_ROWS = 1200;
	localparam int HEAVY_ROWS = 400;
	localparam longint LIMIT_TIME = 64'd3_600_000;

	typedef struct packed {
		ipslb_pkg::load_t baseline;
		ipslb_pkg::load_t slot;
		ipslb_pkg::run_t run;
		logic done;
	} tile_totals_t;

	logic clk;
	logic arst_n;

	ipslb_row_if row_ch();
	ipslb_res_if res_ch();

	interleaved_pe_slot_load_balancer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rows(row_ch),
		.results(res_ch)
	);

	ipslb_pkg::load_t pe_acc [NUM_PES];
	ipslb_pkg::load_t slot_acc [NUM_PES*SLOTS];
	ipslb_pkg::load_t base_peak;
	ipslb_pkg::load_t slot_peak_q;
	tile_totals_t pending_totals [$];

	int mismatches;
	int results_seen;
	int rows_sent;
	int tiles_sent;
	bit send_free;
	bit recv_free;
	int hold_cycles;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void clear_loads();
		foreach (pe_acc[i]) pe_acc[i] = '0;
		foreach (slot_acc[i]) slot_acc[i] = '0;
		base_peak = '0;
		slot_peak_q = '0;
	endfunction

	function automatic ipslb_pkg::load_t add_clamped(ipslb_pkg::load_t a, logic [NZ_W-1:0] b);
		longint sum;
		sum = longint'(a) + longint'(b);
		return (sum > longint'(ipslb_pkg::LOAD_MAX)) ? ipslb_pkg::LOAD_MAX
			: ipslb_pkg::load_t'(sum);
	endfunction

	function automatic tile_totals_t balance_row(logic [ROW_W-1:0] row, logic [NZ_W-1:0] nz,
		logic last);
		int pe;
		int first;
		int pick;
		longint run;
		tile_totals_t t;
		pe = int'(row) % NUM_PES;
		first = pe * SLOTS;
		pick = first;
		pe_acc[pe] = add_clamped(pe_acc[pe], nz);
		if (pe_acc[pe] > base_peak) base_peak = pe_acc[pe];
		for (int s = first + 1; s < first + SLOTS; s++) begin
			if (slot_acc[s] < slot_acc[pick]) pick = s;
		end
		slot_acc[pick] = add_clamped(slot_acc[pick], nz);
		if (slot_acc[pick] > slot_peak_q) slot_peak_q = slot_acc[pick];
		run = (longint'(slot_peak_q) + PAD) * SLOTS;
		if (run > longint'(ipslb_pkg::RUN_MAX)) run = longint'(ipslb_pkg::RUN_MAX);
		t.baseline = base_peak;
		t.slot = slot_peak_q;
		t.run = ipslb_pkg::run_t'(run);
		t.done = last;
		if (last) clear_loads();
		return t;
	endfunction

	function automatic int draw_wait(bit free);
		return free ? 0 : int'($urandom_range(0, 6));
	endfunction

	function automatic logic [ROW_W-1:0] row_for_pe(int pe);
		return ROW_W'($urandom_range(0, (1 << ROW_W) / NUM_PES - 1) * NUM_PES + pe);
	endfunction

	function automatic logic [NZ_W-1:0] pick_nonzeros();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return NZ_W'(WINDOW);
			3: return NZ_W'($urandom);
			default: return NZ_W'($urandom_range(0, WINDOW));
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	// A request that stays valid across back-to-back transfers is never lowered in between.
	task automatic offer_row(logic [ROW_W-1:0] row, logic [NZ_W-1:0] nz, logic last);
		int gap;
		gap = draw_wait(send_free);
		if (gap > 0) begin
			row_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		row_ch.valid <= 1'b1;
		row_ch.local_row <= row;
		row_ch.row_nonzeros <= nz;
		row_ch.tile_last <= last;
		do @(posedge clk); while (!row_ch.ready);
		pending_totals = {pending_totals, balance_row(row, nz, last)};
		rows_sent++;
		if (last) tiles_sent++;
	endtask

	task automatic test_edge_rows();
		send_free = 1'b1;
		recv_free = 1'b0;
		offer_row(19'd0, 14'd0, 1'b0);
		offer_row(19'd0, 14'd5, 1'b0);
		offer_row(19'd128, 14'd5, 1'b0);
		offer_row(19'd256, 14'd3, 1'b0);
		offer_row(19'd384, 14'd3, 1'b0);
		offer_row(19'd512, 14'd3, 1'b0);
		offer_row(19'd640, 14'd0, 1'b0);
		offer_row(19'd768, 14'd2, 1'b0);
		offer_row(19'(ROWS_PER_TILE - 1), NZ_W'(WINDOW), 1'b0);
		offer_row(19'h7FFFF, 14'h3FFF, 1'b0);
		offer_row(19'(ROWS_PER_TILE), NZ_W'(WINDOW), 1'b0);
		offer_row(19'd127, 14'h3FFF, 1'b0);
		offer_row(19'd1, 14'd1, 1'b1);
		offer_row(19'd1, 14'd1, 1'b0);
		offer_row(19'd1, 14'd0, 1'b1);
		offer_row(19'd0, 14'd0, 1'b1);
		send_free = 1'b0;
		offer_row(19'd129, 14'd7, 1'b0);
		offer_row(19'd257, 14'd7, 1'b0);
		offer_row(19'd1, 14'h2AAA, 1'b0);
		offer_row(19'h55555, 14'h1555, 1'b1);
	endtask

	// One PE takes a long run of full rows back to back, so its slots fill in turn.
	task automatic test_heavy_pe();
		send_free = 1'b1;
		recv_free = 1'b1;
		for (int i = 0; i < HEAVY_ROWS; i++) offer_row(row_for_pe(7), '1, 1'b0);
		offer_row(row_for_pe(8), NZ_W'(WINDOW), 1'b0);
		offer_row(row_for_pe(7), '1, 1'b1);
		recv_free = 1'b0;
		send_free = 1'b0;
	endtask

	task automatic test_output_stall();
		hold_cycles = 300;
		send_free = 1'b1;
		recv_free = 1'b0;
		for (int i = 0; i < 120; i++) offer_row(ROW_W'($urandom), pick_nonzeros(), i == 119);
		send_free = 1'b0;
	endtask

	task automatic test_random_tiles();
		int left;
		int len;
		int mode;
		int pe_base;
		int fixed_nz;
		left = RANDOM_ROWS;
		while (left > 0) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
			mode = $urandom_range(0, 4);
			send_free = ($urandom_range(0, 3) == 0);
			recv_free = ($urandom_range(0, 3) == 0);
			pe_base = $urandom_range(0, NUM_PES - 1);
			fixed_nz = $urandom_range(0, WINDOW);
			for (int i = 0; i < len; i++) begin
				logic [ROW_W-1:0] row;
				logic [NZ_W-1:0] nz;
				nz = pick_nonzeros();
				case (mode)
					0: row = ROW_W'($urandom);
					1: row = row_for_pe((pe_base + $urandom_range(0, 3)) % NUM_PES);
					2: begin
						row = row_for_pe(pe_base);
						if ($urandom_range(0, 1)) nz = NZ_W'(fixed_nz);
					end
					3: begin
						// Rows of a few PEs in descending nonzero order, as the scheduler sends them.
						row = row_for_pe((pe_base + $urandom_range(0, 2)) % NUM_PES);
						nz = NZ_W'(fixed_nz);
						fixed_nz = (fixed_nz > 64) ? fixed_nz - $urandom_range(0, 64) : 0;
					end
					default: row = $urandom_range(0, 1) ? ROW_W'($urandom) : row_for_pe(pe_base);
				endcase
				offer_row(row, nz, i == len - 1);
			end
			left -= len;
		end
		send_free = 1'b0;
		recv_free = 1'b0;
	endtask

	initial begin
		int gap;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = draw_wait(recv_free);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	always @(posedge clk) begin
		tile_totals_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (pending_totals.size() == 0) begin
				mismatches++;
				$display("%0t: result expected none pending got baseline_max_load %0d", $time,
					res_ch.baseline_max_load);
			end else begin
				want = pending_totals.pop_front();
				check_field("baseline_max_load", 32'(want.baseline),
					32'(res_ch.baseline_max_load));
				check_field("slot_max_load", 32'(want.slot), 32'(res_ch.slot_max_load));
				check_field("slot_run_length", 32'(want.run), 32'(res_ch.slot_run_length));
				check_field("tile_done", 32'(want.done), 32'(res_ch.tile_done));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		row_ch.valid <= 1'b0;
		row_ch.local_row <= '0;
		row_ch.row_nonzeros <= '0;
		row_ch.tile_last <= 1'b0;
		send_free = 1'b0;
		recv_free = 1'b0;
		hold_cycles = 0;
		mismatches = 0;
		results_seen = 0;
		rows_sent = 0;
		tiles_sent = 0;
		clear_loads();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_rows();
		test_heavy_pe();
		test_output_stall();
		test_random_tiles();
		row_ch.valid <= 1'b0;
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d rows in %0d tiles and checked %0d results.", rows_sent, tiles_sent,
			results_seen);
		$display("Run covered edge rows, a heavily loaded PE, a long output stall and random tiles.");
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(LIMIT_TIME);
		$display("Timed out with %0d results still pending.", pending_totals.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
